// ===== rtl/core/fpwd_pkg.sv =====
// Shared widths, constants, register codes and helpers for the feeder position controller.
package fpwd_pkg;

    localparam int POS_W     = 32;
    localparam int SPD_W     = 16;
    localparam int GAIN_W    = 32;
    localparam int ILIM_W    = 13;
    localparam int TMO_W     = 16;
    localparam int CNT_W     = 16;
    localparam int DRV_W     = 14;
    localparam int INTEG_W   = 40;
    localparam int FRAC_BITS = 24;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 53;
    localparam int CFG_IDX_W = 3;
    localparam int DATA_IN_W = 48;
    localparam int DATA_OUT_W = 16;

    // Product magnitude ceiling and output clamp, both in Q.24
    localparam logic [PROD_W-1:0] PROD_SAT = 64'd1 << 50;
    localparam logic [ACC_W-1:0]  OUT_LIM  = ACC_W'(64'd6000 << FRAC_BITS);
    localparam logic [ACC_W-1:0]  ROUND_ADJ = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);

    // Register reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 32'd2013266;
    localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST = 32'd8389;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST    = 32'd8388608;
    localparam logic [ILIM_W-1:0] INTEGRAL_LIM_RST  = 13'd100;
    localparam logic [TMO_W-1:0]  TIMEOUT_LIM_RST   = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEGRAL_GAIN = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_INTEGRAL_LIM  = 3'd3,
        REG_TIMEOUT_LIM   = 3'd4
    } cfg_reg_t;

    // What the front end hands to the arithmetic pipeline for one tick
    typedef struct packed {
        logic              fault;
        logic              hold;      // boost or capture: clear integral, no command
        logic              err_neg;
        logic [POS_W-1:0]  err_mag;
        logic              spd_neg;
        logic [SPD_W-1:0]  spd_mag;
    } front_t;

    // Saturate an unsigned product magnitude and apply its sign
    function automatic logic signed [ACC_W-1:0] sat_term(input logic [PROD_W-1:0] mag,
                                                         input logic neg);
        logic [ACC_W-1:0] m;
        if (mag > PROD_SAT) begin
            m = ACC_W'(PROD_SAT);
        end else begin
            m = mag[ACC_W-1:0];
        end
        return neg ? $signed(-m) : $signed(m);
    endfunction

    // Symmetric clamp to +-lim
    function automatic logic signed [ACC_W-1:0] clamp_sym(input logic signed [ACC_W-1:0] v,
                                                          input logic [ACC_W-1:0] lim);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed(lim);
        lo = $signed(-lim);
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/fpwd_front.sv =====
// Sample holding, missed-sample watchdog, setpoint capture and error stage.
module fpwd_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic                              advance,
    input  logic                              sample_valid,
    input  logic signed [fpwd_pkg::POS_W-1:0] position,
    input  logic signed [fpwd_pkg::SPD_W-1:0] speed,
    input  logic                              boost,
    input  logic                              capture,
    input  logic [fpwd_pkg::TMO_W-1:0]        timeout_limit,
    output fpwd_pkg::front_t                  front_q
);

    logic signed [fpwd_pkg::POS_W-1:0] setpoint_reg, setpoint_next;
    logic signed [fpwd_pkg::POS_W-1:0] held_pos_reg, held_pos_next;
    logic signed [fpwd_pkg::SPD_W-1:0] held_spd_reg, held_spd_next;
    logic [fpwd_pkg::CNT_W-1:0]        missed_reg, missed_next;
    fpwd_pkg::front_t                  front_reg, front_next;

    logic [fpwd_pkg::CNT_W:0]          cnt_inc;
    logic                              fault;
    logic signed [fpwd_pkg::POS_W:0]   err;
    logic [fpwd_pkg::POS_W:0]          err_abs;
    logic [fpwd_pkg::SPD_W:0]          spd_abs;

    // Watchdog and held state for the word being taken
    always_comb begin
        held_pos_next = sample_valid ? position : held_pos_reg;
        held_spd_next = sample_valid ? speed : held_spd_reg;
        cnt_inc       = {1'b0, missed_reg} + (fpwd_pkg::CNT_W+1)'(1);
        fault         = !sample_valid && (cnt_inc > {1'b0, timeout_limit});
        if (sample_valid || fault) begin
            missed_next = fpwd_pkg::CNT_W'(1);
        end else begin
            missed_next = cnt_inc[fpwd_pkg::CNT_W-1:0];
        end
        setpoint_next = capture ? held_pos_next : setpoint_reg;
    end

    // Error and speed as sign and magnitude for the unsigned multipliers
    always_comb begin
        err     = {setpoint_next[fpwd_pkg::POS_W-1], setpoint_next}
                - {held_pos_next[fpwd_pkg::POS_W-1], held_pos_next};
        err_abs = err[fpwd_pkg::POS_W] ? $unsigned(-err) : $unsigned(err);
        spd_abs = held_spd_next[fpwd_pkg::SPD_W-1]
                ? $unsigned(-{held_spd_next[fpwd_pkg::SPD_W-1], held_spd_next})
                : $unsigned({1'b0, held_spd_next});
        front_next.fault   = fault;
        front_next.hold    = boost || capture;
        front_next.err_neg = err[fpwd_pkg::POS_W];
        front_next.err_mag = err_abs[fpwd_pkg::POS_W-1:0];
        front_next.spd_neg = held_spd_next[fpwd_pkg::SPD_W-1];
        front_next.spd_mag = spd_abs[fpwd_pkg::SPD_W-1:0];
    end

    // Update controller state on every accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= '0;
            held_pos_reg <= '0;
            held_spd_reg <= '0;
            missed_reg   <= '0;
        end else if (accept) begin
            setpoint_reg <= setpoint_next;
            held_pos_reg <= held_pos_next;
            held_spd_reg <= held_spd_next;
            missed_reg   <= missed_next;
        end
    end

    // Stage register toward the multipliers
    always_ff @(posedge aclk) begin
        if (advance) begin
            front_reg <= front_next;
        end
    end

    assign front_q = front_reg;

endmodule

// ===== rtl/core/feeder_position_pid_with_watchdog_core.sv =====
// Top level: feeder position PD+I controller with sample watchdog.
// Each input word passes the front-end, multiplier, saturation and output registers in turn.
// Throughput: one word per cycle; four register stages (front end, multipliers,
// saturation and integral update, output sum) advance together and hold on back-pressure.
// Reset (aresetn low, synchronous) clears the pipeline, all controller state and
// loads the default gains, integral limit 100 and timeout 10.
module feeder_position_pid_with_watchdog_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config write port
    input  logic                                 cfg_we,
    input  logic [fpwd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fpwd_pkg::GAIN_W-1:0]          cfg_data,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [fpwd_pkg::DATA_IN_W-1:0]       s_tdata,  // position[31:0], speed[47:32]
    input  logic [2:0]                           s_tuser,  // sample_valid[0], boost[1], capture[2]
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fpwd_pkg::DATA_OUT_W-1:0]      m_tdata,  // drive_current[13:0], zero[15:14]
    output logic [1:0]                           m_tuser   // send[0], fault[1]
);

    logic [fpwd_pkg::GAIN_W-1:0] prop_gain_reg, integral_gain_reg, deriv_gain_reg;
    logic [fpwd_pkg::ILIM_W-1:0] integral_lim_reg;
    logic [fpwd_pkg::TMO_W-1:0]  timeout_lim_reg;

    logic advance, accept;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    fpwd_pkg::front_t front_q;

    // multiplier stage
    logic [fpwd_pkg::PROD_W-1:0] p_mag_reg, i_mag_reg, d_mag_reg;
    logic                        err_neg2_reg, spd_neg2_reg, fault2_reg, hold2_reg;

    // saturation and integral stage
    logic signed [fpwd_pkg::ACC_W-1:0]   tp_reg, td_reg;
    logic                                fault3_reg, hold3_reg;
    logic signed [fpwd_pkg::INTEG_W-1:0] integ_reg, integ_next;

    // output stage
    logic signed [fpwd_pkg::DRV_W-1:0] drive_reg, drive_next;
    logic                        send_reg, send_next, fault4_reg;

    logic signed [fpwd_pkg::ACC_W-1:0] ti, integ_sum, ilim_clamped, out_sum, out_clamped, out_adj;
    logic [fpwd_pkg::ACC_W-1:0]        ilim;

    // Pipeline moves whenever the output register is free or being drained
    assign advance  = !v4_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= fpwd_pkg::PROP_GAIN_RST;
            integral_gain_reg <= fpwd_pkg::INTEGRAL_GAIN_RST;
            deriv_gain_reg    <= fpwd_pkg::DERIV_GAIN_RST;
            integral_lim_reg  <= fpwd_pkg::INTEGRAL_LIM_RST;
            timeout_lim_reg   <= fpwd_pkg::TIMEOUT_LIM_RST;
        end else if (cfg_we) begin
            case (fpwd_pkg::cfg_reg_t'(cfg_index))
                fpwd_pkg::REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                fpwd_pkg::REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data;
                fpwd_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data;
                fpwd_pkg::REG_INTEGRAL_LIM:  integral_lim_reg  <= cfg_data[fpwd_pkg::ILIM_W-1:0];
                fpwd_pkg::REG_TIMEOUT_LIM:   timeout_lim_reg   <= cfg_data[fpwd_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: watchdog, held sample, setpoint and error
    fpwd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .advance       (advance),
        .sample_valid  (s_tuser[0]),
        .position      ($signed(s_tdata[31:0])),
        .speed         ($signed(s_tdata[47:32])),
        .boost         (s_tuser[1]),
        .capture       (s_tuser[2]),
        .timeout_limit (timeout_lim_reg),
        .front_q       (front_q)
    );

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 2: unsigned magnitude products
    always_ff @(posedge aclk) begin
        if (advance) begin
            p_mag_reg    <= front_q.err_mag * prop_gain_reg;
            i_mag_reg    <= front_q.err_mag * integral_gain_reg;
            d_mag_reg    <= front_q.spd_mag * deriv_gain_reg;
            err_neg2_reg <= front_q.err_neg;
            spd_neg2_reg <= front_q.spd_neg;
            fault2_reg   <= front_q.fault;
            hold2_reg    <= front_q.hold;
        end
    end

    // Stage 3: saturate the terms, integral accumulate and clamp
    always_comb begin
        ti           = fpwd_pkg::sat_term(i_mag_reg, err_neg2_reg);
        ilim         = fpwd_pkg::ACC_W'({integral_lim_reg, {fpwd_pkg::FRAC_BITS{1'b0}}});
        integ_sum    = fpwd_pkg::ACC_W'(integ_reg) + ti;
        ilim_clamped = fpwd_pkg::clamp_sym(integ_sum, ilim);
        if (hold2_reg) begin
            integ_next = '0;
        end else if (fault2_reg) begin
            integ_next = integ_reg;
        end else begin
            integ_next = ilim_clamped[fpwd_pkg::INTEG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (advance && v2_reg) begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tp_reg     <= fpwd_pkg::sat_term(p_mag_reg, err_neg2_reg);
            td_reg     <= fpwd_pkg::sat_term(d_mag_reg, spd_neg2_reg);
            fault3_reg <= fault2_reg;
            hold3_reg  <= hold2_reg;
        end
    end

    // Stage 4: sum terms, clamp, truncate toward zero; zero current on fault or hold
    always_comb begin
        out_sum     = tp_reg + fpwd_pkg::ACC_W'(integ_reg) - td_reg;
        out_clamped = fpwd_pkg::clamp_sym(out_sum, fpwd_pkg::OUT_LIM);
        out_adj     = out_clamped[fpwd_pkg::ACC_W-1] ? out_clamped + $signed(fpwd_pkg::ROUND_ADJ)
                                                     : out_clamped;
        if (fault3_reg) begin
            drive_next = '0;
            send_next  = 1'b1;
        end else if (hold3_reg) begin
            drive_next = '0;
            send_next  = 1'b0;
        end else begin
            drive_next = out_adj[fpwd_pkg::FRAC_BITS +: fpwd_pkg::DRV_W];
            send_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg  <= drive_next;
            send_reg   <= send_next;
            fault4_reg <= fault3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(fpwd_pkg::DATA_OUT_W - fpwd_pkg::DRV_W){1'b0}}, drive_reg};
    assign m_tuser  = {fault4_reg, send_reg};

endmodule

// ===== rtl/core/fpwd_checker.sv =====
// Port-level checks for the feeder position controller, bound to the top level.
module fpwd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A stop is always sent with zero current
    a_fault_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && (m_tdata == 16'd0))
        else $error("fault word is not a zero-current stop");

    // Nothing sent means zero current
    a_nosend_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == 16'd0))
        else $error("suppressed word carries current");

    // Current stays within the output clamp
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[13:0]) <= 14'sd6000)
                  && ($signed(m_tdata[13:0]) >= -14'sd6000)
                  && (m_tdata[15:14] == 2'b00))
        else $error("drive current out of range");

endmodule

bind feeder_position_pid_with_watchdog_core fpwd_checker u_fpwd_checker (.*);
